// ===== rtl/wpm_pkg.sv =====
// Package for the wildcard pattern matcher.
// Holds the fixed field widths, the wildcard byte codes and the register index codes.
// No dependencies; every other file imports it.
package wpm_pkg;

  // Fixed widths of the configuration port and the payload fields.
  localparam int unsigned CfgDataW = 64;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned LenW     = 5;
  localparam int unsigned ByteW    = 8;

  // Wildcard codes in the pattern.
  localparam logic [ByteW-1:0] STAR_BYTE = 8'h2A;
  localparam logic [ByteW-1:0] ANY_BYTE  = 8'h3F;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_PATTERN_LOW  = 2'd0,
    CFG_PATTERN_HIGH = 2'd1,
    CFG_PATTERN_LEN  = 2'd2
  } cfg_idx_e;

endpackage

// ===== rtl/wpm_if.sv =====
// Stream interfaces of the wildcard pattern matcher: text beats in, verdict beats out.
// Depends on wpm_pkg for the byte width.
interface wpm_text_if;
  import wpm_pkg::*;

  logic             valid;
  logic             ready;
  logic [ByteW-1:0] text_byte;
  logic             last_of_text;

  modport source (output valid, output text_byte, output last_of_text, input ready);
  modport sink   (input valid, input text_byte, input last_of_text, output ready);
endinterface

interface wpm_result_if;
  logic valid;
  logic ready;
  logic prefix_matches;
  logic end_of_text;

  modport source (output valid, output prefix_matches, output end_of_text, input ready);
  modport sink   (input valid, input prefix_matches, input end_of_text, output ready);
endinterface

// ===== rtl/wpm_row_update.sv =====
// Combinational update of the wildcard match row for one text byte.
// Depends on wpm_pkg; used by wildcard_pattern_matcher_core.
module wpm_row_update
  import wpm_pkg::*;
#(
  parameter int unsigned PatternMax = 16
) (
  input  logic [CfgDataW-1:0]                 pat_low_i,
  input  logic [CfgDataW-1:0]                 pat_high_i,
  input  logic [LenW-1:0]                     pat_len_i,
  input  logic [PatternMax:0]                 row_i,
  input  logic                                inside_i,
  input  logic [ByteW-1:0]                    text_byte_i,
  output logic [PatternMax:0]                 row_o,
  output logic                                match_o
);

  localparam int unsigned MW = $clog2(PatternMax + 1);

  logic [PatternMax-1:0][ByteW-1:0] pat;
  logic [MW-1:0]                    used_len;
  logic [PatternMax:0]              start_row;
  logic [PatternMax:0]              old_row;
  logic [PatternMax:0]              next_row;

  // Unpack the pattern bytes; bytes at or above PatternMax are never looked at.
  for (genvar k = 0; k < PatternMax; k++) begin : g_pat
    if (k < 8) begin : g_low
      assign pat[k] = pat_low_i[k*ByteW +: ByteW];
    end else begin : g_high
      assign pat[k] = pat_high_i[(k-8)*ByteW +: ByteW];
    end
  end

  // A length beyond the row size is clamped to the row size.
  assign used_len = (pat_len_i > LenW'(PatternMax)) ? MW'(PatternMax) : MW'(pat_len_i);

  // Row at the start of a text: bit 0 set, then the leading run of stars.
  always_comb begin
    start_row    = '0;
    start_row[0] = 1'b1;
    for (int j = 1; j <= int'(PatternMax); j++) begin
      start_row[j] = start_row[j-1] & (pat[j-1] == STAR_BYTE) & (j <= int'(used_len));
    end
  end

  assign old_row = inside_i ? row_i : start_row;

  // One row step: a star ripples from the left, other bytes take the diagonal.
  always_comb begin
    next_row = '0;
    for (int j = 1; j <= int'(PatternMax); j++) begin
      if (j <= int'(used_len)) begin
        priority if (pat[j-1] == STAR_BYTE) begin
          next_row[j] = next_row[j-1] | old_row[j];
        end else if (pat[j-1] == ANY_BYTE || pat[j-1] == text_byte_i) begin
          next_row[j] = old_row[j-1];
        end else begin
          next_row[j] = 1'b0;
        end
      end
    end
  end

  assign row_o   = next_row;
  assign match_o = next_row[used_len];

endmodule

// ===== rtl/wildcard_pattern_matcher_core.sv =====
// Top level of the wildcard pattern matcher: input register, row update, result register.
// Depends on wpm_pkg, wpm_if.sv (wpm_text_if, wpm_result_if) and wpm_row_update.
//
//   Channel   Direction  Beat contents
//   text_i    in         text_byte, last_of_text
//   result_o  out        prefix_matches, end_of_text
//   cfg_*_i   in         register index, 64-bit write data (no read-back)
//
// Each text beat is registered in the input stage; the row update then writes its verdict
// into the result register when that is free or draining. One beat per cycle is sustained
// while result_o.ready holds; the match row and the text-in-progress flag are the only
// state carried between beats. A stalled result register holds its beat; the input
// register fills behind it and then drops ready, so no beat is lost.
// Reset clears the pattern, the match row and both valid flags; no clearing pass.
module wildcard_pattern_matcher_core
  import wpm_pkg::*;
#(
  parameter int unsigned PatternMax = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CfgIdxW-1:0]    cfg_idx_i,
  input  logic [CfgDataW-1:0]   cfg_wdata_i,
  wpm_text_if.sink              text_i,
  wpm_result_if.source          result_o
);

  // Configuration registers.
  logic [CfgDataW-1:0] pat_low_q;
  logic [CfgDataW-1:0] pat_high_q;
  logic [LenW-1:0]     pat_len_q;

  // Input stage.
  logic                s1_valid_q;
  logic [ByteW-1:0]    s1_byte_q;
  logic                s1_last_q;
  logic                s1_fire;
  logic                in_fire;

  // Match state.
  logic [PatternMax:0] row_q;
  logic [PatternMax:0] row_d;
  logic                inside_q;
  logic                match_d;

  // Result register.
  logic                out_valid_q;
  logic                out_match_q;
  logic                out_eot_q;

  // Configuration writes; indexes beyond the list are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_low_q  <= '0;
      pat_high_q <= '0;
      pat_len_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_PATTERN_LOW:  pat_low_q  <= cfg_wdata_i;
        CFG_PATTERN_HIGH: pat_high_q <= cfg_wdata_i;
        CFG_PATTERN_LEN:  pat_len_q  <= cfg_wdata_i[LenW-1:0];
        default: ;
      endcase
    end
  end

  // Handshake: the input stage moves on whenever the result register is free or draining.
  assign s1_fire      = s1_valid_q && (!out_valid_q || result_o.ready);
  assign text_i.ready = !s1_valid_q || s1_fire;
  assign in_fire      = text_i.valid && text_i.ready;

  // Input stage valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (text_i.ready) begin
      s1_valid_q <= text_i.valid;
    end
  end

  // Input stage payload.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_byte_q <= text_i.text_byte;
      s1_last_q <= text_i.last_of_text;
    end
  end

  // Row update for the byte in the input stage.
  wpm_row_update #(
    .PatternMax (PatternMax)
  ) u_row_update (
    .pat_low_i   (pat_low_q),
    .pat_high_i  (pat_high_q),
    .pat_len_i   (pat_len_q),
    .row_i       (row_q),
    .inside_i    (inside_q),
    .text_byte_i (s1_byte_q),
    .row_o       (row_d),
    .match_o     (match_d)
  );

  // Match row and text-in-progress flag; the last byte of a text clears both.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q    <= '0;
      inside_q <= 1'b0;
    end else if (s1_fire) begin
      if (s1_last_q) begin
        row_q    <= '0;
        inside_q <= 1'b0;
      end else begin
        row_q    <= row_d;
        inside_q <= 1'b1;
      end
    end
  end

  // Result register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result register payload.
  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      out_match_q <= match_d;
      out_eot_q   <= s1_last_q;
    end
  end

  assign result_o.valid          = out_valid_q;
  assign result_o.prefix_matches = out_match_q;
  assign result_o.end_of_text    = out_eot_q;

`ifndef SYNTHESIS
  // The last byte of a text always leaves the matcher outside any text.
  a_last_clears_text: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire && s1_last_q |=> !inside_q && (row_q == '0))
    else $error("match state not cleared after last byte of text");

  // Bit 0 of the stored row is never set once a byte has been applied.
  a_row_bit0_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    row_q[0] == 1'b0)
    else $error("stored match row has bit 0 set");

  // An empty pattern never reports a match.
  a_empty_pattern: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire && (pat_len_q == '0) |=> !out_match_q)
    else $error("empty pattern reported a match");

  // An empty result register never blocks the input side.
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> text_i.ready)
    else $error("input stalled with an empty result register");
`endif

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for wildcard_pattern_matcher_core.
// Needs wpm_pkg and the wpm_text_if / wpm_result_if interfaces from the RTL.
// A directed table runs first, then random patterns with texts built from them.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import wpm_pkg::*;

  localparam int unsigned PatMax     = 16;
  localparam int unsigned RandItems  = 700;
  localparam int unsigned CycleLimit = 200000;
  localparam logic [ByteW-1:0] LetterA = 8'h61;

  typedef enum logic {ROW_CFG, ROW_BEAT} row_kind_e;

  // One row of the directed table: a register write or a text beat.
  typedef struct {
    row_kind_e          kind;
    cfg_idx_e           idx;
    logic [CfgDataW-1:0] data;
    logic [ByteW-1:0]   tbyte;
    logic               last;
    bit                 typed;
    bit                 want_match;
  } dir_row_t;

  typedef struct packed {
    logic match;
    logic eot;
  } verdict_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_wdata_i;

  wpm_text_if   text_if ();
  wpm_result_if result_if ();

  wildcard_pattern_matcher_core #(
    .PatternMax(PatMax)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .text_i     (text_if),
    .result_o   (result_if)
  );

  // Shadow copy of the pattern registers and the match row.
  logic [CfgDataW-1:0] pat_lo_m  = '0;
  logic [CfgDataW-1:0] pat_hi_m  = '0;
  logic [LenW-1:0]     pat_len_m = '0;
  logic [PatMax:0]     row_m     = '0;
  logic                in_text_m = 1'b0;

  verdict_t    verdict_q[$];
  dir_row_t    dir_rows[$];
  int unsigned err_count   = 0;
  int unsigned beats_sent  = 0;
  int unsigned burst_left  = 0;
  int unsigned cycle_count = 0;
  int unsigned rx_cycle    = 0;
  int unsigned stall_left  = 0;
  int          rx_mode     = 0;

  // Clock, 8 ns period.
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  task automatic report_mismatch(input string what);
    $display("ERROR at %0t: %s", $time, what);
    err_count++;
  endtask

  function automatic logic [ByteW-1:0] pat_at(input int k);
    return (k < 8) ? pat_lo_m[k*8 +: 8] : pat_hi_m[(k-8)*8 +: 8];
  endfunction

  // Applies one text byte to the shadow row and returns the whole-pattern match bit.
  function automatic logic advance_row(input logic [ByteW-1:0] b, input logic l);
    int          m;
    int          j;
    logic [PatMax:0] prev;
    logic [PatMax:0] nxt;
    logic        hit;
    m = (pat_len_m > PatMax) ? PatMax : int'(pat_len_m);
    // A new text starts from bit 0 plus any leading run of stars.
    if (!in_text_m) begin
      prev = (PatMax+1)'(1);
      for (j = 1; j <= m && pat_at(j-1) == STAR_BYTE; j++) prev[j] = 1'b1;
    end else begin
      prev = row_m;
    end
    nxt = '0;
    for (j = 1; j <= m; j++) begin
      if (pat_at(j-1) == STAR_BYTE) begin
        nxt[j] = nxt[j-1] | prev[j];
      end else if (pat_at(j-1) == ANY_BYTE || pat_at(j-1) == b) begin
        nxt[j] = prev[j-1];
      end else begin
        nxt[j] = 1'b0;
      end
    end
    hit = nxt[m];
    if (l) begin
      row_m     = '0;
      in_text_m = 1'b0;
    end else begin
      row_m     = nxt;
      in_text_m = 1'b1;
    end
    return hit;
  endfunction

  function automatic logic [ByteW-1:0] rand_letter();
    return LetterA + 8'($urandom_range(0, 2));
  endfunction

  // Pattern bytes lean on wildcards and a tiny alphabet so that texts match often.
  function automatic logic [ByteW-1:0] rand_pat_byte();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 20) return STAR_BYTE;
    if (sel < 35) return ANY_BYTE;
    if (sel < 90) return rand_letter();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic void add_cfg(input cfg_idx_e idx, input logic [CfgDataW-1:0] d);
    dir_rows.push_back('{ROW_CFG, idx, d, 8'h00, 1'b0, 1'b0, 1'b0});
  endfunction

  function automatic void add_beat(input logic [ByteW-1:0] b, input logic l,
                                   input bit typed, input bit want_match);
    dir_rows.push_back('{ROW_BEAT, CFG_PATTERN_LOW, '0, b, l, typed, want_match});
  endfunction

  // Sends one text beat in bursts with random gaps, then records the expected verdict.
  task automatic send_beat(input logic [ByteW-1:0] b, input logic l,
                           input bit typed, input bit want_match);
    int       gap;
    logic     hit;
    verdict_t v;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        text_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 3) == 0) ? 120 : $urandom_range(1, 24);
    end
    text_if.valid        <= 1'b1;
    text_if.text_byte    <= b;
    text_if.last_of_text <= l;
    do @(posedge clk_i); while (text_if.ready !== 1'b1);
    hit     = advance_row(b, l);
    v.match = typed ? want_match : hit;
    v.eot   = l;
    verdict_q.push_back(v);
    burst_left--;
    beats_sent++;
  endtask

  // Drops valid and waits until every verdict is back and the pipeline is empty.
  task automatic wait_drained();
    text_if.valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CfgDataW-1:0] d);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= d;
    @(posedge clk_i);
    case (idx)
      CFG_PATTERN_LOW:  pat_lo_m = d;
      CFG_PATTERN_HIGH: pat_hi_m = d;
      CFG_PATTERN_LEN:  pat_len_m = d[LenW-1:0];
      default: ;
    endcase
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // New random pattern; some registers keep their old value now and then.
  task automatic pick_pattern(input int phase);
    logic [CfgDataW-1:0] lo;
    logic [CfgDataW-1:0] hi;
    logic [CfgDataW-1:0] len;
    int                  k;
    int                  sel;
    for (k = 0; k < 8; k++) begin
      lo[k*8 +: 8] = rand_pat_byte();
      hi[k*8 +: 8] = rand_pat_byte();
    end
    if ($urandom_range(0, 7) == 0) lo = {$urandom, $urandom};
    if ($urandom_range(0, 7) == 0) hi = {$urandom, $urandom};
    sel = $urandom_range(0, 99);
    if (sel < 5) len = '0;
    else if (sel < 70) len = CfgDataW'($urandom_range(1, 8));
    else if (sel < 90) len = CfgDataW'($urandom_range(9, PatMax));
    else len = CfgDataW'($urandom_range(PatMax + 1, 31));
    if (phase == 0) len = CfgDataW'(PatMax);
    // Unused upper bits of the length write are random too.
    len[CfgDataW-1:LenW] = (CfgDataW-LenW)'({$urandom, $urandom});
    if (phase == 0 || $urandom_range(0, 3) != 0) write_reg(CFG_PATTERN_LOW, lo);
    if (phase == 0 || $urandom_range(0, 3) != 0) write_reg(CFG_PATTERN_HIGH, hi);
    if (phase == 0 || $urandom_range(0, 4) != 0) write_reg(CFG_PATTERN_LEN, len);
  endtask

  // One whole text: mostly built from the pattern, sometimes mutated, else random.
  task automatic send_text();
    logic [ByteW-1:0] txt[$];
    logic [ByteW-1:0] pb;
    int               m;
    int               k;
    int               mode;
    m    = (pat_len_m > PatMax) ? PatMax : int'(pat_len_m);
    mode = $urandom_range(0, 99);
    if (mode < 60) begin
      for (k = 0; k < m; k++) begin
        pb = pat_at(k);
        if (pb == STAR_BYTE) begin
          repeat ($urandom_range(0, 3)) txt.push_back(rand_letter());
        end else if (pb == ANY_BYTE) begin
          txt.push_back(8'($urandom_range(0, 255)));
        end else begin
          txt.push_back(pb);
        end
      end
      if (txt.size() > 0 && $urandom_range(0, 2) == 0) begin
        txt[$urandom_range(0, txt.size() - 1)] = rand_letter();
      end
    end else if (mode < 90) begin
      repeat ($urandom_range(1, 12)) txt.push_back(rand_letter());
    end else begin
      repeat ($urandom_range(1, 8)) txt.push_back(8'($urandom_range(0, 255)));
    end
    if (txt.size() == 0) txt.push_back(rand_letter());
    for (k = 0; k < txt.size(); k++) send_beat(txt[k], k == txt.size() - 1, 1'b0, 1'b0);
  endtask

  // Result side: check each verdict beat and drive ready in randomly chosen stall modes.
  always @(posedge clk_i) begin : rx_side
    verdict_t want;
    if (rst_ni === 1'b1 && result_if.valid === 1'b1 && result_if.ready === 1'b1) begin
      if (verdict_q.size() == 0) begin
        report_mismatch("verdict beat with nothing expected");
      end else begin
        want = verdict_q.pop_front();
        if (result_if.prefix_matches !== want.match) begin
          report_mismatch($sformatf("prefix_matches got %b want %b",
                                    result_if.prefix_matches, want.match));
        end
        if (result_if.end_of_text !== want.eot) begin
          report_mismatch($sformatf("end_of_text got %b want %b",
                                    result_if.end_of_text, want.eot));
        end
      end
    end
    rx_cycle++;
    if (rx_cycle % 50 == 0) rx_mode = $urandom_range(0, 3);
    case (rx_mode)
      0: result_if.ready <= 1'b1;
      1: result_if.ready <= 1'($urandom_range(0, 1));
      2: result_if.ready <= (rx_cycle % 4 == 0);
      default: begin
        if (stall_left > 0) begin
          stall_left--;
          result_if.ready <= 1'b0;
        end else if ($urandom_range(0, 7) == 0) begin
          stall_left = $urandom_range(2, 9);
          result_if.ready <= 1'b0;
        end else begin
          result_if.ready <= 1'b1;
        end
      end
    endcase
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("wildcard_pattern_matcher_core test failed");
      $finish;
    end
  end

  // Stimulus: reset, directed table, random phases, final drain.
  initial begin : stimulus
    int unsigned rand_start;
    int          phase;
    rst_ni               <= 1'b0;
    cfg_we_i             <= 1'b0;
    cfg_idx_i            <= CFG_PATTERN_LOW;
    cfg_wdata_i          <= '0;
    text_if.valid        <= 1'b0;
    text_if.text_byte    <= '0;
    text_if.last_of_text <= 1'b0;

    // Empty pattern after reset never matches.
    add_beat(8'hFF, 1'b0, 1'b1, 1'b0);
    add_beat(8'h00, 1'b1, 1'b1, 1'b0);
    // A lone star matches everything.
    add_cfg(CFG_PATTERN_LOW, 64'h2A);
    add_cfg(CFG_PATTERN_LEN, 64'd1);
    add_beat(8'h78, 1'b1, 1'b1, 1'b1);
    add_beat(8'hFF, 1'b0, 1'b1, 1'b1);
    add_beat(8'h00, 1'b1, 1'b1, 1'b1);
    // Length above the maximum is clipped: sixteen stars.
    add_cfg(CFG_PATTERN_LOW, 64'h2A2A_2A2A_2A2A_2A2A);
    add_cfg(CFG_PATTERN_HIGH, 64'h2A2A_2A2A_2A2A_2A2A);
    add_cfg(CFG_PATTERN_LEN, 64'hFFFF_FFFF_FFFF_FFFF);
    add_beat(8'h71, 1'b0, 1'b1, 1'b1);
    add_beat(8'h72, 1'b1, 1'b1, 1'b1);
    // Two question marks need exactly two bytes.
    add_cfg(CFG_PATTERN_LOW, 64'h3F3F_3F3F_3F3F_3F3F);
    add_cfg(CFG_PATTERN_HIGH, 64'h3F3F_3F3F_3F3F_3F3F);
    add_cfg(CFG_PATTERN_LEN, 64'd2);
    add_beat(8'h61, 1'b0, 1'b1, 1'b0);
    add_beat(8'h62, 1'b0, 1'b1, 1'b1);
    add_beat(8'h63, 1'b1, 1'b1, 1'b0);
    // Literal extreme bytes 0xFF then 0x00.
    add_cfg(CFG_PATTERN_LOW, 64'h00FF);
    add_beat(8'hFF, 1'b0, 1'b1, 1'b0);
    add_beat(8'h00, 1'b1, 1'b1, 1'b1);
    add_beat(8'hFF, 1'b1, 1'b1, 1'b0);
    // Pattern "a?*b" with a star in the middle.
    add_cfg(CFG_PATTERN_LOW, 64'h622A_3F61);
    add_cfg(CFG_PATTERN_LEN, 64'd4);
    add_beat(8'h61, 1'b0, 1'b0, 1'b0);
    add_beat(8'h78, 1'b0, 1'b0, 1'b0);
    add_beat(8'h62, 1'b0, 1'b0, 1'b0);
    add_beat(8'h7A, 1'b0, 1'b0, 1'b0);
    add_beat(8'h62, 1'b1, 1'b0, 1'b0);
    add_beat(8'h61, 1'b0, 1'b0, 1'b0);
    add_beat(8'h62, 1'b1, 1'b0, 1'b0);
    // Length changed in the middle of a text: the row carries over.
    add_beat(8'h61, 1'b0, 1'b0, 1'b0);
    add_cfg(CFG_PATTERN_LEN, 64'd2);
    add_beat(8'h7A, 1'b1, 1'b0, 1'b0);

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        wait_drained();
        write_reg(dir_rows[i].idx, dir_rows[i].data);
      end else begin
        send_beat(dir_rows[i].tbyte, dir_rows[i].last, dir_rows[i].typed,
                  dir_rows[i].want_match);
      end
    end

    // Random phases; some end inside a text so the next pattern acts on a live row.
    rand_start = beats_sent;
    phase      = 0;
    while (beats_sent - rand_start < RandItems) begin
      wait_drained();
      pick_pattern(phase);
      repeat ($urandom_range(2, 8)) send_text();
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 3)) send_beat(rand_letter(), 1'b0, 1'b0, 1'b0);
      end
      phase++;
    end

    wait_drained();
    repeat (6) @(posedge clk_i);
    if (err_count == 0) begin
      $display("wildcard_pattern_matcher_core test passed");
    end else begin
      $display("wildcard_pattern_matcher_core test failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/wpm_pkg.sv
rtl/wpm_if.sv
rtl/wpm_row_update.sv
rtl/wildcard_pattern_matcher_core.sv
verif/tb.sv
